@@ sv/psd3_pkg.sv @@
// Package for the point to segment distance pipeline.
// Payload structs, register indexes and the square root step function.
package psd3_pkg;

  localparam int unsigned RegIdxW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned SqrtSteps = 4;   // result bits resolved per stage
  localparam int unsigned SqrtStages = 32 / SqrtSteps;

  typedef enum logic [RegIdxW-1:0] {
    REG_CX = 3'd0,
    REG_CY = 3'd1,
    REG_CZ = 3'd2,
    REG_DX = 3'd3,
    REG_DY = 3'd4,
    REG_DZ = 3'd5,
    REG_HL = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] pt_x;
    logic signed [31:0] pt_y;
    logic signed [31:0] pt_z;
    logic        [30:0] move_time;
    logic signed [31:0] pt_vel_x;
    logic signed [31:0] pt_vel_y;
    logic signed [31:0] pt_vel_z;
    logic signed [31:0] seg_vel_x;
    logic signed [31:0] seg_vel_y;
    logic signed [31:0] seg_vel_z;
  } psd3_in_t;

  typedef struct packed {
    logic        [63:0] dist_squared;
    logic        [31:0] dist_res;
    logic signed [31:0] seg_param;
    logic signed [31:0] near_x;
    logic signed [31:0] near_y;
    logic signed [31:0] near_z;
  } psd3_out_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] root;
  } sqrt_st_t;

  // Saturate a 65 bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [64:0] hi;
    logic signed [64:0] lo;
    hi = 65'sd2147483647;
    lo = -65'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    if (v < lo) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Square, saturated to 64 bits.
  function automatic logic [63:0] sq_sat(input logic signed [32:0] v);
    logic [32:0] m;
    m = v[32] ? 33'(-v) : 33'(v);
    if (m[32]) return '1;
    return m[31:0] * m[31:0];
  endfunction

  // One restoring step: decides bit b of the root.
  function automatic sqrt_st_t sqrt_step(input sqrt_st_t s, input int unsigned b);
    sqrt_st_t r;
    logic [64:0] trial;
    r = s;
    trial = (({33'b0, s.root} << (b + 1)) | (65'd1 << (2 * b)));
    if ({1'b0, s.rem} >= trial) begin
      r.rem = 64'({1'b0, s.rem} - trial);
      r.root = s.root | (32'd1 << b);
    end
    return r;
  endfunction

endpackage

@@ sv/point_segment_distance_3d.sv @@
// Point to segment distance in 3D: one query a cycle while not stalled,
// valid/stall pipeline; one result per clock unless the output stalls. The
// depth is set by the 32 bit multipliers (motion, dot, projection, squares)
// and the square root, resolved four bits per stage. A stall freezes the
// whole pipeline; an output register keeps the finished result. Uses psd3_pkg.
module point_segment_distance_3d
  import psd3_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [RegIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  psd3_in_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output psd3_out_t           out_data
);

  localparam int unsigned Depth = 8 + SqrtStages;

  logic signed [31:0] cen [3];
  logic signed [15:0] dir [3];
  logic        [30:0] half;

  always_ff @(posedge clk) begin
    if (rst) begin
      cen[0] <= '0; cen[1] <= '0; cen[2] <= '0;
      dir[0] <= 16'sd16384; dir[1] <= '0; dir[2] <= '0;
      half <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CX: cen[0] <= cfg_data;
        REG_CY: cen[1] <= cfg_data;
        REG_CZ: cen[2] <= cfg_data;
        REG_DX: dir[0] <= cfg_data[15:0];
        REG_DY: dir[1] <= cfg_data[15:0];
        REG_DZ: dir[2] <= cfg_data[15:0];
        REG_HL: half <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  logic [Depth-1:0] vld;
  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld[Depth-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[Depth-2:0], in_valid};
  end

  // s1: motion products
  logic signed [31:0] s1_p [3];
  logic signed [31:0] s1_c [3];
  logic signed [63:0] s1_tp [3];
  logic signed [63:0] s1_ts [3];
  // s2: moved point and centre
  logic signed [31:0] s2_q [3];
  logic signed [31:0] s2_m [3];
  // s3: dot products
  logic signed [31:0] s3_q [3];
  logic signed [31:0] s3_m [3];
  logic signed [48:0] s3_pr [3];
  // s4: parameter
  logic signed [31:0] s4_q [3];
  logic signed [31:0] s4_m [3];
  logic signed [31:0] s4_s;
  // s5: projection products
  logic signed [31:0] s5_q [3];
  logic signed [31:0] s5_m [3];
  logic signed [31:0] s5_s;
  logic signed [47:0] s5_sd [3];
  // s6: closest point, differences
  logic signed [31:0] s6_n [3];
  logic signed [32:0] s6_df [3];
  logic signed [31:0] s6_s;
  // s7: squares
  logic signed [31:0] s7_n [3];
  logic signed [31:0] s7_s;
  logic [63:0] s7_sq [3];
  // s8: sum
  logic signed [31:0] s8_n [3];
  logic signed [31:0] s8_s;
  logic [63:0] s8_d2;
  // square root stages
  sqrt_st_t sq_st [SqrtStages+1];
  logic [63:0] sq_d2 [SqrtStages+1];
  logic signed [31:0] sq_s [SqrtStages+1];
  logic signed [31:0] sq_n [SqrtStages+1][3];

  logic signed [65:0] dot_sum;
  logic signed [51:0] dot_sh;
  logic signed [52:0] e_pos;
  logic signed [52:0] e_neg;
  logic [64:0] d2_a;
  logic [65:0] d2_b;

  always_comb begin
    dot_sum = 66'(s3_pr[0]) + 66'(s3_pr[1]) + 66'(s3_pr[2]);
    dot_sh = 52'(dot_sum >>> 14);
    e_pos = 53'($signed({22'b0, half}));
    e_neg = -e_pos;
    d2_a = {1'b0, s7_sq[0]} + {1'b0, s7_sq[1]};
    d2_b = {1'b0, d2_a} + {2'b0, s7_sq[2]};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_p[0] <= in_data.pt_x; s1_p[1] <= in_data.pt_y; s1_p[2] <= in_data.pt_z;
      s1_c[0] <= cen[0]; s1_c[1] <= cen[1]; s1_c[2] <= cen[2];
      s1_tp[0] <= $signed({1'b0, in_data.move_time}) * in_data.pt_vel_x;
      s1_tp[1] <= $signed({1'b0, in_data.move_time}) * in_data.pt_vel_y;
      s1_tp[2] <= $signed({1'b0, in_data.move_time}) * in_data.pt_vel_z;
      s1_ts[0] <= $signed({1'b0, in_data.move_time}) * in_data.seg_vel_x;
      s1_ts[1] <= $signed({1'b0, in_data.move_time}) * in_data.seg_vel_y;
      s1_ts[2] <= $signed({1'b0, in_data.move_time}) * in_data.seg_vel_z;
      for (int i = 0; i < 3; i++) begin
        s2_q[i] <= sat32(65'(s1_p[i]) + 65'(s1_tp[i] >>> 16));
        s2_m[i] <= sat32(65'(s1_c[i]) + 65'(s1_ts[i] >>> 16));
        s3_q[i] <= s2_q[i];
        s3_m[i] <= s2_m[i];
        s3_pr[i] <= dir[i] * (33'(s2_q[i]) - 33'(s2_m[i]));
        s4_q[i] <= s3_q[i];
        s4_m[i] <= s3_m[i];
        s5_q[i] <= s4_q[i];
        s5_m[i] <= s4_m[i];
        s5_sd[i] <= s4_s * dir[i];
        s6_n[i] <= sat32(65'(s5_m[i]) + 65'(s5_sd[i] >>> 14));
        s6_df[i] <= 33'(sat32(65'(s5_m[i]) + 65'(s5_sd[i] >>> 14))) - 33'(s5_q[i]);
        s7_n[i] <= s6_n[i];
        s7_sq[i] <= sq_sat(s6_df[i]);
        s8_n[i] <= s7_n[i];
      end
      if (53'(dot_sh) <= e_neg) s4_s <= e_neg[31:0];
      else if (53'(dot_sh) >= e_pos) s4_s <= e_pos[31:0];
      else s4_s <= dot_sh[31:0];
      s5_s <= s4_s;
      s6_s <= s5_s;
      s7_s <= s6_s;
      s8_s <= s7_s;
      s8_d2 <= (d2_b[65:64] != 2'b0) ? '1 : d2_b[63:0];
    end
  end

  always_comb begin
    sq_st[0].rem = s8_d2;
    sq_st[0].root = '0;
    sq_d2[0] = s8_d2;
    sq_s[0] = s8_s;
    sq_n[0] = s8_n;
  end

  for (genvar g = 0; g < SqrtStages; g++) begin : g_sqrt
    sqrt_st_t nxt;
    always_comb begin
      nxt = sq_st[g];
      for (int k = 0; k < SqrtSteps; k++)
        nxt = sqrt_step(nxt, 31 - g * SqrtSteps - k);
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_st[g+1] <= nxt;
        sq_d2[g+1] <= sq_d2[g];
        sq_s[g+1] <= sq_s[g];
        sq_n[g+1] <= sq_n[g];
      end
    end
  end

  always_comb begin
    out_data.dist_squared = sq_d2[SqrtStages];
    out_data.dist_res = sq_st[SqrtStages].root;
    out_data.seg_param = sq_s[SqrtStages];
    out_data.near_x = sq_n[SqrtStages][0];
    out_data.near_y = sq_n[SqrtStages][1];
    out_data.near_z = sq_n[SqrtStages][2];
  end

endmodule

@@ sv/psd3_checker.sv @@
// Port checker for point_segment_distance_3d, attached by bind.
// Depends on psd3_pkg.
module psd3_checker
  import psd3_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input psd3_out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_back: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stalled without output stall");

  a_sqrt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({32'b0, out_data.dist_res} * {32'b0, out_data.dist_res}
                   <= {64'b0, out_data.dist_squared}))
    else $error("root too large");

  a_rst: assert property (@(posedge clk) $past(rst) && !rst |-> !out_valid)
    else $error("result after reset");

endmodule

bind point_segment_distance_3d psd3_checker u_psd3_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
